### rtl/core/dssf_pkg.sv
// Shared types, constants and lookup functions of the decimal seven-segment formatter.
package dssf_pkg;

	localparam int VALUE_W        = 16;
	localparam int DIGIT_W        = 4;
	localparam int SEG_W          = 8;
	localparam int SEG_FIELDS     = 4;
	localparam int MAX_DIGITS     = 5;
	localparam int NUM_DIGITS_DEF = 4;
	localparam int RECIP_W        = 17;
	localparam int PROD_W         = VALUE_W + RECIP_W;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 3;
	localparam int OUT_W          = (SEG_FIELDS + 1) * SEG_W;

	localparam logic [SEG_W-1:0] DP_BIT         = 8'h80;
	localparam logic [SEG_W-1:0] CMD_DISPLAY_ON = 8'h88;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO_BLANKING     = 3'd0,
		REG_DECIMAL_POINT_POS = 3'd1,
		REG_DISPLAYED_DIGITS  = 3'd2,
		REG_ROUND_ENABLE      = 3'd3,
		REG_BRIGHTNESS        = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic       zero_blanking;
		logic [2:0] decimal_point_pos;
		logic [2:0] displayed_digits;
		logic       round_enable;
		logic [2:0] brightness;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		zero_blanking:     1'b0,
		decimal_point_pos: 3'd0,
		displayed_digits:  3'd3,
		round_enable:      1'b1,
		brightness:        3'd5
	};

	// Reciprocal of 10^k, scaled by 2^recip_shift(k); exact for every 16-bit value.
	// A 16-bit value divided by 10^5 is always zero.
	function automatic logic [RECIP_W-1:0] recip_mult(input int k);
		logic [RECIP_W-1:0] m;
		unique case (k)
			1:       m = 17'd52429;
			2:       m = 17'd83887;
			3:       m = 17'd67109;
			4:       m = 17'd107375;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic int recip_shift(input int k);
		int s;
		unique case (k)
			1:       s = 19;
			2:       s = 23;
			3:       s = 26;
			4:       s = 30;
			default: s = 0;
		endcase
		return s;
	endfunction

	// Segments a..g in bits 0..6; codes above nine light nothing.
	function automatic logic [SEG_W-1:0] seg_lookup(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0:    s = 8'h3f;
			4'd1:    s = 8'h06;
			4'd2:    s = 8'h5b;
			4'd3:    s = 8'h4f;
			4'd4:    s = 8'h66;
			4'd5:    s = 8'h6d;
			4'd6:    s = 8'h7d;
			4'd7:    s = 8'h07;
			4'd8:    s = 8'h7f;
			4'd9:    s = 8'h6f;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

### rtl/core/dssf_divide.sv
// Splits a binary value into decimal digits by reciprocal multiplication.
module dssf_divide #(
	parameter int NUM_DIGITS = dssf_pkg::NUM_DIGITS_DEF
) (
	input  logic [dssf_pkg::VALUE_W-1:0] value,
	output logic [dssf_pkg::DIGIT_W-1:0] digit [NUM_DIGITS]
);
	import dssf_pkg::*;

	// quot[k] is value / 10^k; every product is taken from the value itself.
	logic [VALUE_W-1:0] quot [NUM_DIGITS+1];

	assign quot[0] = value;

	for (genvar k = 1; k <= NUM_DIGITS; k++) begin : g_quot
		localparam logic [RECIP_W-1:0] MULT  = recip_mult(k);
		localparam int                 SHIFT = recip_shift(k);
		logic [PROD_W-1:0] prod;
		assign prod    = PROD_W'(value) * PROD_W'(MULT);
		assign quot[k] = VALUE_W'(prod >> SHIFT);
	end

	// Digit i counts from the left, so it is quotient N-1-i less ten times the next one.
	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_digit
		logic [VALUE_W-1:0] hi;
		logic [VALUE_W-1:0] rem;
		assign hi       = quot[NUM_DIGITS-i];
		assign rem      = quot[NUM_DIGITS-1-i] - ((hi << 3) + (hi << 1));
		assign digit[i] = rem[DIGIT_W-1:0];
	end

endmodule

### rtl/core/dssf_format.sv
// Rounds the digits, blanks leading zeros and builds segment and control bytes.
module dssf_format #(
	parameter int NUM_DIGITS = dssf_pkg::NUM_DIGITS_DEF
) (
	input  dssf_pkg::cfg_t               cfg,
	input  logic [dssf_pkg::DIGIT_W-1:0] digit [NUM_DIGITS],
	output logic [dssf_pkg::SEG_W-1:0]   seg [dssf_pkg::SEG_FIELDS],
	output logic [dssf_pkg::SEG_W-1:0]   control
);
	import dssf_pkg::*;

	logic [DIGIT_W-1:0] rounded [NUM_DIGITS];
	logic [SEG_W-1:0]   segs    [NUM_DIGITS];
	logic               carry;
	logic [DIGIT_W:0]   sum;
	logic               blanking;
	logic [SEG_W-1:0]   s;

	// With rounding enabled, the rightmost digit is dropped and a carry ripples left while digits overflow.
	always_comb begin
		rounded = digit;
		carry   = 1'b0;
		sum     = '0;
		if (cfg.round_enable) begin
			carry = (digit[NUM_DIGITS-1] > DIGIT_W'(5));
			rounded[NUM_DIGITS-1] = '0;
			for (int i = NUM_DIGITS - 2; i >= 0; i--) begin
				sum = {1'b0, digit[i]} + (DIGIT_W+1)'(carry);
				if (sum > (DIGIT_W+1)'(9)) begin
					rounded[i] = '0;
					carry      = 1'b1;
				end else begin
					rounded[i] = sum[DIGIT_W-1:0];
					carry      = 1'b0;
				end
			end
		end
	end

	always_comb begin
		blanking = cfg.zero_blanking;
		s        = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			s = seg_lookup(rounded[i]);
			if (blanking && rounded[i] == '0) begin
				if (i < NUM_DIGITS - 1) begin
					s = '0;
				end
			end else begin
				blanking = 1'b0;
				if (3'(i) == cfg.decimal_point_pos) begin
					s = s | DP_BIT;
				end
			end
			if (3'(i) >= cfg.displayed_digits) begin
				s = '0;
			end
			segs[i] = s;
		end
	end

	for (genvar f = 0; f < SEG_FIELDS; f++) begin : g_field
		if (f < NUM_DIGITS) begin : g_used
			assign seg[f] = segs[f];
		end else begin : g_unused
			assign seg[f] = '0;
		end
	end

	assign control = CMD_DISPLAY_ON + SEG_W'(cfg.brightness);

endmodule

### rtl/core/decimal_seven_segment_formatter.sv
// Top level of the decimal seven-segment formatter: stream ports, pipeline and registers.
// The accepting edge loads the input register; the digits from the reciprocal multipliers
// are then loaded into the digit register, and the formatted bytes into the result
// register, which drives m_tdata.
// Throughput is one request per cycle while m_tready stays high; each of the three stages
// stalls only while full and the one after it cannot move, and refills once it drains.
// arst_n clears the stage valid flags at once and loads the register reset values
// (no blanking, point on the leftmost digit, three digits shown, rounding on, brightness 5).
module decimal_seven_segment_formatter #(
	parameter int NUM_DIGITS = dssf_pkg::NUM_DIGITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dssf_pkg::VALUE_W-1:0]    s_tdata,   // value
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dssf_pkg::OUT_W-1:0]      m_tdata,   // seg_digit0..seg_digit3, control_byte
	input  logic                            cfg_we,
	input  logic [dssf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dssf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dssf_pkg::*;

	// Configuration registers. The user must change them only while the pipeline is empty,
	// which the block does not enforce, as the formatting stage reads them directly.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ZERO_BLANKING:     cfg_q.zero_blanking     <= cfg_data[0];
				REG_DECIMAL_POINT_POS: cfg_q.decimal_point_pos <= cfg_data;
				REG_DISPLAYED_DIGITS:  cfg_q.displayed_digits  <= cfg_data;
				REG_ROUND_ENABLE:      cfg_q.round_enable      <= cfg_data[0];
				REG_BRIGHTNESS:        cfg_q.brightness        <= cfg_data;
				default:               cfg_q                   <= cfg_q;
			endcase
		end
	end

	// Stage valids. Each stage may load when it is empty or when the stage after it
	// moves, which keeps requests flowing every cycle while the output is taken.
	logic valid_s1;
	logic valid_s2;
	logic out_valid_q;
	logic adv_out;
	logic adv_s2;
	logic adv_s1;

	assign adv_out  = !out_valid_q || m_tready;
	assign adv_s2   = !valid_s2 || adv_out;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Payload: input value, decimal digits, packed result bytes.
	logic [VALUE_W-1:0] value_s1;
	logic [DIGIT_W-1:0] digit_c  [NUM_DIGITS];
	logic [DIGIT_W-1:0] digit_s2 [NUM_DIGITS];
	logic [SEG_W-1:0]   seg_c    [SEG_FIELDS];
	logic [SEG_W-1:0]   control_c;
	logic [OUT_W-1:0]   result_c;
	logic [OUT_W-1:0]   result_q;

	dssf_divide #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_divide (
		.value(value_s1),
		.digit(digit_c)
	);

	dssf_format #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_format (
		.cfg    (cfg_q),
		.digit  (digit_s2),
		.seg    (seg_c),
		.control(control_c)
	);

	// Leftmost digit in the lowest byte, the control byte on top.
	for (genvar f = 0; f < SEG_FIELDS; f++) begin : g_pack
		assign result_c[f*SEG_W +: SEG_W] = seg_c[f];
	end
	assign result_c[SEG_FIELDS*SEG_W +: SEG_W] = control_c;

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			value_s1 <= s_tdata;
		end
		if (adv_s2 && valid_s1) begin
			digit_s2 <= digit_c;
		end
		if (adv_out && valid_s2) begin
			result_q <= result_c;
		end
	end

	assign m_tdata = result_q;

endmodule

### tb/sv/decimal_seven_segment_formatter_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every display frame of the formatter and compares it with the block.
module decimal_seven_segment_formatter_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [dssf_pkg::VALUE_W-1:0]    s_tdata,   // value
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [dssf_pkg::OUT_W-1:0]      m_tdata,   // seg_digit0..seg_digit3, control_byte
	input  logic                            cfg_we,
	input  logic [dssf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dssf_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatch_count,
	output int                              pending_frames,
	output int                              results_checked
);
	import dssf_pkg::*;

	localparam int DIGITS = NUM_DIGITS_DEF;

	cfg_t             regs = CFG_RESET;
	logic [OUT_W-1:0] expected_frames [$];
	int               error_tally = 0;
	int               checked_tally = 0;

	function automatic logic [SEG_W-1:0] segment_code(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 8'h3f;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5b;
			4'd3: s = 8'h4f;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6d;
			4'd6: s = 8'h7d;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7f;
			4'd9: s = 8'h6f;
			default: s = '0;
		endcase
		return s;
	endfunction

	function automatic logic [OUT_W-1:0] format_display(input logic [VALUE_W-1:0] value,
			input cfg_t c);
		logic [DIGIT_W-1:0] digit [DIGITS];
		logic [OUT_W-1:0]   frame;
		logic [SEG_W-1:0]   s;
		int unsigned        rest;
		int                 carry;
		bit                 blanking;
		rest = 32'(value);
		for (int i = DIGITS - 1; i >= 0; i--) begin
			digit[i] = DIGIT_W'(rest % 10);
			rest = rest / 10;
		end
		// Rounding clears the last digit and ripples a carry leftward; the top carry is lost.
		if (c.round_enable) begin
			carry = (int'(digit[DIGITS-1]) > 5) ? 1 : 0;
			digit[DIGITS-1] = '0;
			for (int i = DIGITS - 2; i >= 0; i--) begin
				if (int'(digit[i]) + carry > 9) begin
					digit[i] = '0;
					carry = 1;
				end else begin
					digit[i] = DIGIT_W'(int'(digit[i]) + carry);
					carry = 0;
				end
			end
		end
		frame = '0;
		blanking = c.zero_blanking;
		for (int i = 0; i < DIGITS; i++) begin
			s = segment_code(digit[i]);
			if (blanking && digit[i] == '0) begin
				// The rightmost digit still shows a zero, but never a point.
				if (i < DIGITS - 1)
					s = '0;
			end else begin
				blanking = 1'b0;
				if (i == int'(c.decimal_point_pos))
					s = s | DP_BIT;
			end
			if (i >= int'(c.displayed_digits))
				s = '0;
			if (i < SEG_FIELDS)
				frame[i*SEG_W +: SEG_W] = s;
		end
		frame[SEG_FIELDS*SEG_W +: SEG_W] = CMD_DISPLAY_ON + SEG_W'(c.brightness);
		return frame;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		logic [OUT_W-1:0] want;
		if (!arst_n) begin
			regs = CFG_RESET;
			expected_frames.delete();
			pending_frames <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_frames.push_back(format_display(s_tdata, regs));
			if (m_tvalid && m_tready) begin
				if (expected_frames.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
					error_tally++;
				end else begin
					want = expected_frames.pop_front();
					for (int f = 0; f <= SEG_FIELDS; f++) begin
						if (m_tdata[f*SEG_W +: SEG_W] !== want[f*SEG_W +: SEG_W]) begin
							$display("%0t: %s mismatch, expected %h, actual %h", $time,
								(f == SEG_FIELDS) ? "control_byte" : $sformatf("seg_digit%0d", f),
								want[f*SEG_W +: SEG_W], m_tdata[f*SEG_W +: SEG_W]);
							error_tally++;
						end
					end
					checked_tally++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_ZERO_BLANKING:     regs.zero_blanking     = cfg_data[0];
					REG_DECIMAL_POINT_POS: regs.decimal_point_pos = cfg_data;
					REG_DISPLAYED_DIGITS:  regs.displayed_digits  = cfg_data;
					REG_ROUND_ENABLE:      regs.round_enable      = cfg_data[0];
					REG_BRIGHTNESS:        regs.brightness        = cfg_data;
					default: ;
				endcase
			end
			pending_frames <= expected_frames.size();
		end
		mismatch_count  <= error_tally;
		results_checked <= checked_tally;
	end

endmodule

### tb/sv/decimal_seven_segment_formatter_tb.sv
`timescale 1ns / 1ps
// Top of the formatter testbench: clock, reset, request and register stimulus, and the verdict.
module decimal_seven_segment_formatter_tb;
	import dssf_pkg::*;

	// The slowest legal run is 1023 requests with the longest idle gaps on each side plus
	// the pipeline and the drains; the limit leaves a wide margin on top of that.
	localparam int CYCLE_LIMIT     = 400000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int RANDOM_PHASES   = 20;
	localparam int REQS_PER_PHASE  = 50;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [VALUE_W-1:0]    s_tdata;   // value
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;   // seg_digit0..seg_digit3, control_byte
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatch_count;
	int pending_frames;
	int results_checked;
	int cycle_count = 0;
	int requests_sent = 0;
	int settings_applied = 0;

	// Per-phase switches: when clear, that side never idles, giving back-to-back stretches.
	bit sender_idle = 1'b0;
	bit receiver_idle = 1'b0;

	decimal_seven_segment_formatter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	decimal_seven_segment_formatter_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.pending_frames  (pending_frames),
		.results_checked (results_checked)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int draw_wait(input bit enabled);
		return enabled ? int'($urandom_range(0, 13)) : 0;
	endfunction

	function automatic cfg_t make_setting(input bit zb, input int dp, input int dd,
			input bit rnd, input int br);
		cfg_t c;
		c.zero_blanking     = zb;
		c.decimal_point_pos = 3'(dp);
		c.displayed_digits  = 3'(dd);
		c.round_enable      = rnd;
		c.brightness        = 3'(br);
		return c;
	endfunction

	// Values are steered toward the interesting regions: the rounding threshold, carry
	// chains through nines, small numbers with many leading zeros, and wraparound.
	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(0, 4))
			0: v = VALUE_W'($urandom);
			1: v = VALUE_W'($urandom_range(0, 9999));
			2: v = VALUE_W'($urandom_range(0, 5) * 10000 + $urandom_range(0, 999) * 10
				+ $urandom_range(4, 7));
			3: v = VALUE_W'($urandom_range(0, 5) * 10000 + 9990 + $urandom_range(0, 9));
			default: v = VALUE_W'($urandom_range(0, 150));
		endcase
		return v;
	endfunction

	// One request: optional idle gap with junk on the data bus, then hold until accepted.
	// A zero gap leaves tvalid high so consecutive requests go out back to back.
	task automatic send_value(input logic [VALUE_W-1:0] value);
		int gap;
		gap = draw_wait(sender_idle);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= VALUE_W'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		requests_sent++;
	endtask

	// Stop sending and wait until every predicted frame has come back, then let the pipeline settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_frames != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// Writes all five registers. The single-bit registers get random upper data bits, which
	// the block must ignore, and now and then an unused index is written as well.
	task automatic apply_setting(input cfg_t c);
		logic [1:0] pad;
		pad = 2'($urandom_range(0, 3));
		write_reg(REG_ZERO_BLANKING, {pad, c.zero_blanking});
		write_reg(REG_DECIMAL_POINT_POS, c.decimal_point_pos);
		write_reg(REG_DISPLAYED_DIGITS, c.displayed_digits);
		pad = 2'($urandom_range(0, 3));
		write_reg(REG_ROUND_ENABLE, {pad, c.round_enable});
		write_reg(REG_BRIGHTNESS, c.brightness);
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// When receiver_idle is set, the receiver stalls a random number of cycles before each result it takes.
	initial begin : receiver
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(receiver_idle);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin : stimulus
		cfg_t setting;
		int   pause_at;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed group under the reset register values: rounding on, three digits, point
		// on the leftmost digit. Covers both value extremes, the wraparound of a carry off
		// the top (9996), the rounding threshold, and values above 9999.
		sender_idle   = 1'b0;
		receiver_idle = 1'b1;
		send_value(16'd0);
		send_value(16'd65535);
		send_value(16'd9996);
		send_value(16'd9995);
		send_value(16'd1234);
		send_value(16'd10000);
		send_value(16'd96);
		send_value(16'd5);

		// Leading-zero blanking with rounding: a carry can turn a blanked zero into a one,
		// an all-zero value leaves only the rightmost zero, and the point sits on the last digit.
		drain();
		sender_idle = 1'b1;
		apply_setting(make_setting(1'b1, 3, 4, 1'b1, 7));
		send_value(16'd0);
		send_value(16'd6);
		send_value(16'd96);
		send_value(16'd9996);
		send_value(16'd5);
		send_value(16'd1006);
		send_value(16'd1);

		// Blanking without rounding: the point on a blanked digit must not appear.
		drain();
		receiver_idle = 1'b0;
		apply_setting(make_setting(1'b1, 2, 4, 1'b0, 0));
		send_value(16'd0);
		send_value(16'd7);
		send_value(16'd40);
		send_value(16'hAAAA);
		send_value(16'h5555);
		send_value(16'd9999);
		send_value(16'd100);
		send_value(16'd2);

		// Random phases, each under its own register setting. The first two use the extreme
		// settings (everything clear, everything at its top code), the rest draw every
		// register over its full data width. Every phase may pause the sender midway until
		// all results are back; phase three always does.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			if (p == 0)
				setting = make_setting(1'b0, 0, 0, 1'b0, 0);
			else if (p == 1)
				setting = make_setting(1'b1, 7, 7, 1'b1, 7);
			else
				setting = make_setting(1'($urandom_range(0, 1)), int'($urandom_range(0, 7)),
					int'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
					int'($urandom_range(0, 7)));
			sender_idle   = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
			receiver_idle = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
			apply_setting(setting);
			pause_at = (p == 3 || $urandom_range(0, 4) == 0) ?
				int'($urandom_range(1, REQS_PER_PHASE - 1)) : -1;
			for (int i = 0; i < REQS_PER_PHASE; i++) begin
				if (i == pause_at)
					drain();
				send_value(pick_value());
			end
		end

		drain();
		$display("Sent %0d requests and checked %0d display frames under %0d register settings,",
			requests_sent, results_checked, settings_applied + 1);
		$display("with rounding, blanking, point placement and digit counts at their extremes.");
		if (mismatch_count == 0 && pending_frames == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
